### rtl/ppts_pkg.sv
// Shared constants, codes and interface types of the pipeline task scheduler.
package ppts_pkg;

    localparam int MAX_STAGES = 16;
    localparam int MAX_MICRO  = 64;
    localparam int NUM_Q      = 4;

    localparam int STAGE_W = $clog2(MAX_STAGES);
    localparam int SCNT_W  = $clog2(MAX_STAGES + 1);
    localparam int PTR_W   = $clog2(MAX_MICRO);
    localparam int CNT_W   = $clog2(MAX_MICRO + 1);
    localparam int VAL_W   = $clog2(MAX_MICRO + 1);
    localparam int Q_W     = $clog2(NUM_Q);
    localparam int KIND_W  = 3;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 7;
    localparam int NSCFG_W = 5;
    localparam int NMCFG_W = 7;

    // Queue indexes inside a stage.
    localparam logic [Q_W-1:0] Q_FWD = 2'd0;
    localparam logic [Q_W-1:0] Q_RC  = 2'd1;
    localparam logic [Q_W-1:0] Q_BI  = 2'd2;
    localparam logic [Q_W-1:0] Q_BW  = 2'd3;

    // Task kinds as reported on the result port.
    localparam logic [KIND_W-1:0] K_FWD  = 3'd0;
    localparam logic [KIND_W-1:0] K_RC   = 3'd1;
    localparam logic [KIND_W-1:0] K_BI   = 3'd2;
    localparam logic [KIND_W-1:0] K_BW   = 3'd3;
    localparam logic [KIND_W-1:0] K_IDLE = 3'd4;

    // Schedule modes.
    localparam logic [MODE_W-1:0] MODE_GPIPE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_STAGES = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MICRO  = 2'd2;

    // Push steps of a tick, in the order the stages would apply them.
    localparam logic [1:0] STEP_BELOW = 2'd0;
    localparam logic [1:0] STEP_OWN_A = 2'd1;
    localparam logic [1:0] STEP_OWN_B = 2'd2;
    localparam logic [1:0] STEP_ABOVE = 2'd3;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic               clear;
        logic               load_en;
        logic [VAL_W-1:0]   load_val;
        logic               pick_en;
        logic               mini_en;
        logic               push_en;
        logic [1:0]         push_step;
        logic               res_shift;
        logic               gp;
        logic               alt;
        logic [SCNT_W-1:0]  num_stages;
        logic [VAL_W-1:0]   num_micro;
    } ctl_t;

    // A push request handed to a neighboring cell.
    typedef struct packed {
        logic             valid;
        logic [Q_W-1:0]   q;
        logic [VAL_W-1:0] val;
    } nbr_t;

    // One result as it moves down the output chain.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PTR_W-1:0]  mini;
    } res_t;

endpackage

### rtl/pipeline_parallel_task_scheduler_unit.sv
// Top level: configuration, tick sequencer and the row of stage cells.
// Restart beat: clears the queues, loads micro-batches 1..num_micro into stage 0, no result.
// Tick beat: pick, read, then one result per stage in use, with pushes alongside.
// Next beat once results are taken and pushes are done.
// Reset is asynchronous: queues empty, counters cleared; queue storage is not reset.
module pipeline_parallel_task_scheduler_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ppts_pkg::STAGE_W-1:0]    stage,
    output logic [ppts_pkg::KIND_W-1:0]     task_kind,
    output logic [ppts_pkg::PTR_W-1:0]      micro_index,
    output logic                            last,
    output logic                            all_idle,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ppts_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [ppts_pkg::CDATA_W-1:0]    cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_PICK = 5'b00100,
        ST_MINI = 5'b01000,
        ST_PUSH = 5'b10000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [ppts_pkg::MODE_W-1:0]     mode_reg;
    logic [ppts_pkg::NSCFG_W-1:0]    nstages_reg;
    logic [ppts_pkg::NMCFG_W-1:0]    nmicro_reg;
    logic [ppts_pkg::PTR_W-1:0]      load_reg;
    logic [1:0]                      step_reg;
    logic [ppts_pkg::SCNT_W-1:0]     left_reg;
    logic [ppts_pkg::STAGE_W-1:0]    stage_reg;
    logic                            idle_reg;

    logic [ppts_pkg::SCNT_W-1:0]     eff_s;
    logic [ppts_pkg::VAL_W-1:0]      eff_m;
    logic                            in_fire;
    logic                            out_fire;
    logic                            none;
    ppts_pkg::ctl_t                  ctl;
    ppts_pkg::nbr_t                  up_w    [ppts_pkg::MAX_STAGES];
    ppts_pkg::nbr_t                  dn_w    [ppts_pkg::MAX_STAGES];
    ppts_pkg::nbr_t                  below_w [ppts_pkg::MAX_STAGES];
    ppts_pkg::nbr_t                  above_w [ppts_pkg::MAX_STAGES];
    ppts_pkg::res_t                  res_w   [ppts_pkg::MAX_STAGES];
    ppts_pkg::res_t                  rin_w   [ppts_pkg::MAX_STAGES];
    logic [ppts_pkg::MAX_STAGES-1:0] busy_w;

    // Effective stage and micro-batch counts.
    always_comb
    begin
        if (nstages_reg == '0)
        begin
            eff_s = ppts_pkg::SCNT_W'(1);
        end
        else if (nstages_reg > ppts_pkg::NSCFG_W'(ppts_pkg::MAX_STAGES))
        begin
            eff_s = ppts_pkg::SCNT_W'(ppts_pkg::MAX_STAGES);
        end
        else
        begin
            eff_s = ppts_pkg::SCNT_W'(nstages_reg);
        end
        if (nmicro_reg > ppts_pkg::NMCFG_W'(ppts_pkg::MAX_MICRO))
        begin
            eff_m = ppts_pkg::VAL_W'(ppts_pkg::MAX_MICRO);
        end
        else
        begin
            eff_m = ppts_pkg::VAL_W'(nmicro_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && (left_reg == '0);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = left_reg != '0;
    assign out_fire  = out_valid && out_ready;
    assign none      = ~|busy_w;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            nstages_reg <= ppts_pkg::NSCFG_W'(4);
            nmicro_reg  <= ppts_pkg::NMCFG_W'(8);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ppts_pkg::REG_MODE:   mode_reg    <= cfg_data[ppts_pkg::MODE_W-1:0];
                ppts_pkg::REG_STAGES: nstages_reg <= cfg_data[ppts_pkg::NSCFG_W-1:0];
                ppts_pkg::REG_MICRO:  nmicro_reg  <= cfg_data;
                default:              mode_reg    <= mode_reg;
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!restart)
                    begin
                        state_next = ST_PICK;
                    end
                    else if (eff_m != '0)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if ({1'b0, load_reg} + ppts_pkg::VAL_W'(1) == eff_m)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PICK:
            begin
                state_next = ST_MINI;
            end
            ST_MINI:
            begin
                state_next = none ? ST_IDLE : ST_PUSH;
            end
            ST_PUSH:
            begin
                if (step_reg == ppts_pkg::STEP_ABOVE)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers and output bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            load_reg  <= '0;
            step_reg  <= ppts_pkg::STEP_BELOW;
            left_reg  <= '0;
            stage_reg <= '0;
            idle_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
            begin
                load_reg <= load_reg + ppts_pkg::PTR_W'(1);
            end
            else
            begin
                load_reg <= '0;
            end
            if (state_reg == ST_PUSH)
            begin
                step_reg <= step_reg + 2'd1;
            end
            else
            begin
                step_reg <= ppts_pkg::STEP_BELOW;
            end
            if (state_reg == ST_MINI)
            begin
                left_reg  <= eff_s;
                stage_reg <= '0;
                idle_reg  <= none;
            end
            else if (out_fire)
            begin
                left_reg  <= left_reg - ppts_pkg::SCNT_W'(1);
                stage_reg <= stage_reg + ppts_pkg::STAGE_W'(1);
            end
        end
    end

    // Control broadcast to the cells.
    always_comb
    begin
        ctl.clear      = in_fire && restart;
        ctl.load_en    = state_reg == ST_LOAD;
        ctl.load_val   = {1'b0, load_reg} + ppts_pkg::VAL_W'(1);
        ctl.pick_en    = state_reg == ST_PICK;
        ctl.mini_en    = state_reg == ST_MINI;
        ctl.push_en    = state_reg == ST_PUSH;
        ctl.push_step  = step_reg;
        ctl.res_shift  = out_fire;
        ctl.gp         = mode_reg == ppts_pkg::MODE_GPIPE;
        ctl.alt        = mode_reg == ppts_pkg::MODE_ALT;
        ctl.num_stages = eff_s;
        ctl.num_micro  = eff_m;
    end

    // Row of stage cells with neighbor links.
    for (genvar g = 0; g < ppts_pkg::MAX_STAGES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign below_w[g] = '0;
        end
        else
        begin : g_mid
            assign below_w[g] = up_w[g-1];
        end
        if (g == ppts_pkg::MAX_STAGES - 1)
        begin : g_top
            assign above_w[g] = '0;
            assign rin_w[g]   = '{kind: ppts_pkg::K_IDLE, mini: '0};
        end
        else
        begin : g_low
            assign above_w[g] = dn_w[g+1];
            assign rin_w[g]   = res_w[g+1];
        end

        ppts_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_id  (ppts_pkg::STAGE_W'(g)),
            .ctl       (ctl),
            .below_req (below_w[g]),
            .above_req (above_w[g]),
            .up_req    (up_w[g]),
            .dn_req    (dn_w[g]),
            .res_in    (rin_w[g]),
            .res_out   (res_w[g]),
            .busy      (busy_w[g])
        );
    end

    // Result beat comes from the head of the chain.
    assign stage       = stage_reg;
    assign task_kind   = res_w[0].kind;
    assign micro_index = res_w[0].mini;
    assign last        = left_reg == ppts_pkg::SCNT_W'(1);
    assign all_idle    = idle_reg;

endmodule

### rtl/ppts_cell.sv
// One pipeline stage: its four task queues, pick logic and output chain link.
module ppts_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ppts_pkg::STAGE_W-1:0]   stage_id,
    input  ppts_pkg::ctl_t                 ctl,
    input  ppts_pkg::nbr_t                 below_req,
    input  ppts_pkg::nbr_t                 above_req,
    output ppts_pkg::nbr_t                 up_req,
    output ppts_pkg::nbr_t                 dn_req,
    input  ppts_pkg::res_t                 res_in,
    output ppts_pkg::res_t                 res_out,
    output logic                           busy
);

    localparam int MEM_DEPTH = ppts_pkg::NUM_Q * ppts_pkg::MAX_MICRO;
    localparam int ADDR_W    = ppts_pkg::Q_W + ppts_pkg::PTR_W;

    logic [ppts_pkg::PTR_W-1:0]  head_reg [ppts_pkg::NUM_Q];
    logic [ppts_pkg::CNT_W-1:0]  cnt_reg  [ppts_pkg::NUM_Q];
    logic [ppts_pkg::CNT_W-1:0]  fd_reg;
    logic [ppts_pkg::CNT_W-1:0]  bd_reg;
    logic                        nif_reg;
    logic [ppts_pkg::KIND_W-1:0] kind_reg;
    logic [ppts_pkg::VAL_W-1:0]  mini_reg;
    logic [ppts_pkg::VAL_W-1:0]  rdata_reg;
    ppts_pkg::res_t              res_reg;
    logic [ppts_pkg::VAL_W-1:0]  mem [MEM_DEPTH];

    logic                          active;
    logic                          lastst;
    logic                          first;
    logic [ppts_pkg::NUM_Q-1:0]    has;
    logic [ppts_pkg::NSCFG_W-1:0]  warm;
    logic                          in_warm;
    logic signed [8:0]             cool_th;
    logic                          in_cool;
    logic [ppts_pkg::KIND_W-1:0]   pick_kind;
    logic [ppts_pkg::Q_W-1:0]      pick_q;
    logic                          fd_inc;
    logic                          bd_inc;
    logic                          nif_next;
    logic [ADDR_W-1:0]             raddr;
    logic                          push_v;
    logic [ppts_pkg::Q_W-1:0]      push_q;
    logic [ppts_pkg::VAL_W-1:0]    push_val;
    logic                          push_do;
    logic [ADDR_W-1:0]             waddr;

    // Stage position relative to the stages in use.
    assign active = {1'b0, stage_id} < ctl.num_stages;
    assign lastst = {1'b0, stage_id} == (ctl.num_stages - ppts_pkg::SCNT_W'(1));
    assign first  = stage_id == '0;

    always_comb
    begin
        for (int k = 0; k < ppts_pkg::NUM_Q; k++)
        begin
            has[k] = cnt_reg[k] != '0;
        end
    end

    // Warmup and cooldown bounds of the one-forward-one-backward rule.
    assign warm    = ctl.num_stages - {1'b0, stage_id} - ppts_pkg::NSCFG_W'(1);
    assign in_warm = fd_reg < {2'b00, warm};
    assign cool_th = $signed({2'b00, ctl.num_micro}) - $signed({4'b0000, warm});
    assign in_cool = $signed({2'b00, bd_reg}) >= cool_th;

    // Task selection for this stage.
    always_comb
    begin
        pick_kind = ppts_pkg::K_IDLE;
        fd_inc    = 1'b0;
        bd_inc    = 1'b0;
        nif_next  = nif_reg;
        if (!active)
        begin
            pick_kind = ppts_pkg::K_IDLE;
        end
        else if (ctl.alt)
        begin
            priority if (in_warm)
            begin
                if (has[ppts_pkg::Q_FWD])
                begin
                    pick_kind = ppts_pkg::K_FWD;
                    fd_inc    = 1'b1;
                end
            end
            else if (in_cool)
            begin
                if (has[ppts_pkg::Q_BI])
                begin
                    pick_kind = ppts_pkg::K_BI;
                    bd_inc    = 1'b1;
                end
            end
            else if (nif_reg && has[ppts_pkg::Q_FWD])
            begin
                pick_kind = ppts_pkg::K_FWD;
                fd_inc    = 1'b1;
                nif_next  = 1'b0;
            end
            else if (!nif_reg && has[ppts_pkg::Q_BI])
            begin
                pick_kind = ppts_pkg::K_BI;
                bd_inc    = 1'b1;
                nif_next  = 1'b1;
            end
            else
            begin
                pick_kind = ppts_pkg::K_IDLE;
            end
        end
        else if (ctl.gp)
        begin
            priority if (has[ppts_pkg::Q_FWD]) pick_kind = ppts_pkg::K_FWD;
            else if (has[ppts_pkg::Q_BI])      pick_kind = ppts_pkg::K_BI;
            else if (has[ppts_pkg::Q_RC])      pick_kind = ppts_pkg::K_RC;
            else if (has[ppts_pkg::Q_BW])      pick_kind = ppts_pkg::K_BW;
            else                               pick_kind = ppts_pkg::K_IDLE;
        end
        else
        begin
            priority if (has[ppts_pkg::Q_BW]) pick_kind = ppts_pkg::K_BW;
            else if (has[ppts_pkg::Q_BI])     pick_kind = ppts_pkg::K_BI;
            else if (has[ppts_pkg::Q_RC])     pick_kind = ppts_pkg::K_RC;
            else if (has[ppts_pkg::Q_FWD])    pick_kind = ppts_pkg::K_FWD;
            else                              pick_kind = ppts_pkg::K_IDLE;
        end
    end

    assign pick_q = pick_kind[ppts_pkg::Q_W-1:0];
    assign raddr  = {pick_q, head_reg[pick_q]};

    // Push selected for the current load or push step.
    always_comb
    begin
        push_v   = 1'b0;
        push_q   = ppts_pkg::Q_FWD;
        push_val = mini_reg;
        if (ctl.load_en)
        begin
            push_v   = first;
            push_val = ctl.load_val;
        end
        else if (ctl.push_en)
        begin
            unique case (ctl.push_step)
                ppts_pkg::STEP_BELOW:
                begin
                    push_v   = below_req.valid;
                    push_q   = below_req.q;
                    push_val = below_req.val;
                end
                ppts_pkg::STEP_OWN_A:
                begin
                    if (kind_reg == ppts_pkg::K_FWD && lastst)
                    begin
                        if (!ctl.gp)
                        begin
                            push_v = 1'b1;
                            push_q = ppts_pkg::Q_BI;
                        end
                        else if (mini_reg == ctl.num_micro)
                        begin
                            push_v = 1'b1;
                            push_q = ppts_pkg::Q_RC;
                        end
                    end
                    else if (kind_reg == ppts_pkg::K_BI)
                    begin
                        push_v = 1'b1;
                        push_q = ppts_pkg::Q_BW;
                    end
                    else if (kind_reg == ppts_pkg::K_RC)
                    begin
                        push_v = 1'b1;
                        push_q = ppts_pkg::Q_BI;
                    end
                end
                ppts_pkg::STEP_OWN_B:
                begin
                    if (kind_reg == ppts_pkg::K_BI && ctl.gp && lastst
                        && mini_reg > ppts_pkg::VAL_W'(1))
                    begin
                        push_v   = 1'b1;
                        push_q   = ppts_pkg::Q_RC;
                        push_val = mini_reg - ppts_pkg::VAL_W'(1);
                    end
                end
                ppts_pkg::STEP_ABOVE:
                begin
                    push_v   = above_req.valid;
                    push_q   = above_req.q;
                    push_val = above_req.val;
                end
                default:
                begin
                    push_v = 1'b0;
                end
            endcase
        end
    end

    assign push_do = push_v && (cnt_reg[push_q] < ppts_pkg::CNT_W'(ppts_pkg::MAX_MICRO));
    assign waddr   = {push_q, head_reg[push_q] + cnt_reg[push_q][ppts_pkg::PTR_W-1:0]};

    // Requests handed to the neighboring stages.
    always_comb
    begin
        up_req.valid = kind_reg == ppts_pkg::K_FWD && !lastst;
        up_req.q     = ppts_pkg::Q_FWD;
        up_req.val   = mini_reg;
        dn_req.valid = 1'b0;
        dn_req.q     = ppts_pkg::Q_RC;
        dn_req.val   = mini_reg;
        if (!first && kind_reg == ppts_pkg::K_BI && !ctl.gp)
        begin
            dn_req.valid = 1'b1;
            dn_req.q     = ctl.alt ? ppts_pkg::Q_BI : ppts_pkg::Q_RC;
        end
        else if (!first && kind_reg == ppts_pkg::K_RC && ctl.gp)
        begin
            dn_req.valid = 1'b1;
        end
    end

    // Queue pointers, progress counters and result chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ppts_pkg::NUM_Q; k++)
            begin
                head_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
            fd_reg   <= '0;
            bd_reg   <= '0;
            nif_reg  <= 1'b1;
            kind_reg <= ppts_pkg::K_IDLE;
            res_reg  <= '{kind: ppts_pkg::K_IDLE, mini: '0};
        end
        else
        begin
            if (ctl.clear)
            begin
                for (int k = 0; k < ppts_pkg::NUM_Q; k++)
                begin
                    head_reg[k] <= '0;
                    cnt_reg[k]  <= '0;
                end
                fd_reg   <= '0;
                bd_reg   <= '0;
                nif_reg  <= 1'b1;
                kind_reg <= ppts_pkg::K_IDLE;
            end
            else
            begin
                if (ctl.pick_en)
                begin
                    kind_reg <= pick_kind;
                    nif_reg  <= nif_next;
                    if (fd_inc)
                    begin
                        fd_reg <= fd_reg + ppts_pkg::CNT_W'(1);
                    end
                    if (bd_inc)
                    begin
                        bd_reg <= bd_reg + ppts_pkg::CNT_W'(1);
                    end
                    if (pick_kind != ppts_pkg::K_IDLE)
                    begin
                        head_reg[pick_q] <= head_reg[pick_q] + ppts_pkg::PTR_W'(1);
                        cnt_reg[pick_q]  <= cnt_reg[pick_q] - ppts_pkg::CNT_W'(1);
                    end
                end
                if (push_do)
                begin
                    cnt_reg[push_q] <= cnt_reg[push_q] + ppts_pkg::CNT_W'(1);
                end
            end
            if (ctl.mini_en)
            begin
                res_reg.kind <= kind_reg;
                res_reg.mini <= (kind_reg == ppts_pkg::K_IDLE) ? '0
                              : ppts_pkg::PTR_W'(rdata_reg - ppts_pkg::VAL_W'(1));
            end
            else if (ctl.res_shift)
            begin
                res_reg <= res_in;
            end
        end
    end

    // Popped micro-batch kept for the push steps.
    always_ff @(posedge clk)
    begin
        if (ctl.mini_en)
        begin
            mini_reg <= rdata_reg;
        end
    end

    // Queue storage: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (push_do)
        begin
            mem[waddr] <= push_val;
        end
        rdata_reg <= mem[raddr];
    end

    assign res_out = res_reg;
    assign busy    = kind_reg != ppts_pkg::K_IDLE;

endmodule
